// File: design/urs_pkg.sv
// Shared types and constants for the ultrasonic ranging scheduler.
// No dependencies; used by every module of the block through scoped names.
package urs_pkg;

    localparam int ECHO_LINES = 3;
    localparam int DIST_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_LEAD   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIG_PULSE  = 3'd5;

    // configuration reset values
    localparam logic [15:0] RST_SCALE      = 16'd11239;
    localparam logic [15:0] RST_MAX_MM     = 16'd4000;
    localparam logic [15:0] RST_SETTLE     = 16'd10000;
    localparam logic [15:0] RST_TIMEOUT    = 16'd30000;
    localparam logic [7:0]  RST_TRIG_LEAD  = 8'd2;
    localparam logic [7:0]  RST_TRIG_PULSE = 8'd10;

    typedef logic [DIST_W-1:0] t_dist;

    typedef struct packed {
        logic [15:0] scale;
        logic [15:0] max_mm;
        logic [15:0] settle;
        logic [15:0] timeout;
        logic [7:0]  lead;
        logic [7:0]  pulse;
    } t_cfg;

    // end-of-measurement status from the sequencer to the range unit
    typedef struct packed {
        logic done;     // a measurement ends this tick
        logic tout;     // it ended by timeout
        logic echo_ok;  // it ended on a complete echo
    } t_meas;

endpackage

// File: design/urs_timing.sv
// Per-tick measurement sequencer: settle, trigger pulse, echo edge timing.
// Depends on urs_pkg (t_cfg, t_meas, ECHO_LINES).
module urs_timing #(
    parameter int SENSOR_COUNT = 3,
    parameter int TICK_BITS    = 16,
    parameter int IDX_W        = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_fire,
    input  logic [urs_pkg::ECHO_LINES-1:0]    i_echo,
    input  urs_pkg::t_cfg                     i_cfg,
    output urs_pkg::t_meas                    o_meas,
    output logic [TICK_BITS-1:0]              o_width,
    output logic [IDX_W-1:0]                  o_idx,
    output logic [IDX_W-1:0]                  o_idx_next,
    output logic [urs_pkg::ECHO_LINES-1:0]    o_trig_next
);

    localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;

    logic                 r_phase, n_phase;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [TICK_BITS-1:0] r_elapsed, n_elapsed;
    logic [TICK_BITS-1:0] r_rise, n_rise;
    logic                 r_seen, n_seen;
    logic                 r_prev, n_prev;

    logic [TICK_BITS-1:0] tick;
    logic                 level;
    logic                 rise_edge;
    logic                 fall_edge;
    logic                 finish;
    logic [CW-1:0]        lead_ext;
    logic [CW-1:0]        last_hi;
    logic [2:0]           trig_sel;
    urs_pkg::t_meas       meas;

    // echo level of one sensor; lines past the physical ones read low
    function automatic logic echo_of(input logic [urs_pkg::ECHO_LINES-1:0] lv,
                                     input logic [IDX_W-1:0] idx);
        logic [2:0] sel;
        sel = 3'(idx);
        return (sel < 3'(urs_pkg::ECHO_LINES)) ? lv[sel[1:0]] : 1'b0;
    endfunction

    always_comb begin
        tick      = (&r_elapsed) ? r_elapsed : r_elapsed + 1'b1;
        level     = echo_of(i_echo, r_idx);
        rise_edge = 1'b0;
        fall_edge = 1'b0;
        finish    = 1'b0;
        meas      = '0;
        n_phase   = r_phase;
        n_idx     = r_idx;
        n_elapsed = tick;
        n_rise    = r_rise;
        n_seen    = r_seen;

        if (!r_phase) begin
            if (CW'(tick) >= CW'(i_cfg.settle)) begin
                n_phase   = 1'b1;
                n_elapsed = '0;
                n_rise    = '0;
                n_seen    = 1'b0;
            end
        end else begin
            rise_edge = level && !r_prev;
            fall_edge = !level && r_prev && r_seen;
            if (rise_edge) begin
                n_rise = tick;
                n_seen = 1'b1;
            end
            // a complete echo wins over a timeout in the same tick
            if (fall_edge) begin
                meas.done    = 1'b1;
                meas.echo_ok = 1'b1;
                finish       = 1'b1;
            end else if (CW'(tick) >= CW'(i_cfg.timeout)) begin
                meas.done = 1'b1;
                meas.tout = 1'b1;
                finish    = 1'b1;
            end
            if (finish) begin
                n_idx     = (r_idx == IDX_W'(SENSOR_COUNT - 1)) ? '0 : r_idx + 1'b1;
                n_elapsed = '0;
                n_phase   = 1'b0;
                n_seen    = 1'b0;
            end
        end

        n_prev = echo_of(i_echo, n_idx);

        // trigger high for lead < elapsed <= lead + pulse
        lead_ext    = CW'(i_cfg.lead);
        last_hi     = CW'({1'b0, i_cfg.lead} + {1'b0, i_cfg.pulse});
        trig_sel    = 3'(n_idx);
        o_trig_next = '0;
        if (n_phase && (CW'(n_elapsed) > lead_ext) && (CW'(n_elapsed) <= last_hi) &&
            (trig_sel < 3'(urs_pkg::ECHO_LINES))) begin
            o_trig_next = urs_pkg::ECHO_LINES'(1) << trig_sel[1:0];
        end
    end

    assign o_meas     = meas;
    assign o_width    = tick - r_rise;
    assign o_idx      = r_idx;
    assign o_idx_next = n_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_idx     <= '0;
            r_elapsed <= '0;
            r_rise    <= '0;
            r_seen    <= 1'b0;
            r_prev    <= 1'b0;
        end else if (i_fire) begin
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_elapsed <= n_elapsed;
            r_rise    <= n_rise;
            r_seen    <= n_seen;
            r_prev    <= n_prev;
        end
    end

endmodule

// File: design/urs_range.sv
// Echo width to millimetres, per-sensor distance store and nearest-distance pick.
// Depends on urs_pkg (t_cfg, t_meas, t_dist, ECHO_LINES).
module urs_range #(
    parameter int SENSOR_COUNT = 3,
    parameter int TICK_BITS    = 16,
    parameter int IDX_W        = 2
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_fire,
    input  urs_pkg::t_meas                              i_meas,
    input  logic [TICK_BITS-1:0]                        i_width,
    input  logic [IDX_W-1:0]                            i_idx,
    input  urs_pkg::t_cfg                               i_cfg,
    output urs_pkg::t_dist [urs_pkg::ECHO_LINES-1:0]    o_dist_next,
    output urs_pkg::t_dist                              o_nearest_next
);

    localparam int CW = (TICK_BITS > 16) ? TICK_BITS : 16;
    localparam int PW = TICK_BITS + 16;

    urs_pkg::t_dist       r_dist [SENSOR_COUNT];
    urs_pkg::t_dist       n_dist [SENSOR_COUNT];
    logic [PW-1:0]        prod;
    logic [TICK_BITS-1:0] mm;
    urs_pkg::t_dist       mm_ok;
    urs_pkg::t_dist       best;

    always_comb begin
        prod  = PW'(i_width) * PW'(i_cfg.scale);
        mm    = prod[PW-1:16];
        // zero and out-of-range readings store as "no reading"
        mm_ok = ((mm == '0) || (CW'(mm) > CW'(i_cfg.max_mm))) ? '0 : 16'(mm);

        for (int i = 0; i < SENSOR_COUNT; i++) begin
            n_dist[i] = r_dist[i];
        end
        if (i_meas.done) begin
            n_dist[i_idx] = i_meas.echo_ok ? mm_ok : '0;
        end

        best = i_cfg.max_mm;
        for (int i = 0; i < SENSOR_COUNT; i++) begin
            if ((n_dist[i] != '0) && (n_dist[i] < best)) begin
                best = n_dist[i];
            end
        end
    end

    assign o_nearest_next = best;

    for (genvar k = 0; k < urs_pkg::ECHO_LINES; k++) begin : g_dist
        if (k < SENSOR_COUNT) begin : g_on
            assign o_dist_next[k] = n_dist[k];
        end else begin : g_off
            assign o_dist_next[k] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_dist[i] <= '0;
            end
        end else if (i_fire) begin
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                r_dist[i] <= n_dist[i];
            end
        end
    end

endmodule

// File: design/ultrasonic_ranging_scheduler.sv
// Top level of the round-robin ultrasonic ranging scheduler.
// Depends on urs_pkg, urs_timing and urs_range.
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  ----------------------------------------
//  tick in   in         i_valid / o_stall   i_echo_levels
//  result    out        o_valid / i_stall   o_trigger_lines, o_distance_*, o_nearest_*,
//                                           o_active_sensor, o_measurement_done,
//                                           o_timed_out
//  config    in         i_cfg_we            i_cfg_idx, i_cfg_data
//
// One request may enter per clock while o_stall is low. A request passes the tick
// register, then one pass through the sequencer and the width-times-scale
// multiplier into the result register.
// Reset (synchronous, active low) clears the sequencer, the distance store, both
// valid flags and loads the default configuration.
// A stalled result holds; the tick register keeps taking requests until it is full
// too, and o_stall rises only then.
module ultrasonic_ranging_scheduler #(
    parameter int SENSOR_COUNT = 3,
    parameter int TICK_BITS    = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // tick requests
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic [urs_pkg::ECHO_LINES-1:0]          i_echo_levels,
    // results
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [urs_pkg::ECHO_LINES-1:0]          o_trigger_lines,
    output logic [urs_pkg::DIST_W-1:0]              o_distance_zero,
    output logic [urs_pkg::DIST_W-1:0]              o_distance_one,
    output logic [urs_pkg::DIST_W-1:0]              o_distance_two,
    output logic [urs_pkg::DIST_W-1:0]              o_nearest_distance,
    output logic [1:0]                              o_active_sensor,
    output logic                                    o_measurement_done,
    output logic                                    o_timed_out,
    // configuration writes
    input  logic                                    i_cfg_we,
    input  logic [urs_pkg::CFG_IDX_W-1:0]           i_cfg_idx,
    input  logic [urs_pkg::CFG_DATA_W-1:0]          i_cfg_data
);

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    // configuration
    urs_pkg::t_cfg r_cfg;

    // tick register
    logic                               r_in_valid;
    logic [urs_pkg::ECHO_LINES-1:0]     r_in_echo;

    // result register
    logic                               r_out_valid;
    logic [urs_pkg::ECHO_LINES-1:0]     r_trig;
    urs_pkg::t_dist [urs_pkg::ECHO_LINES-1:0] r_dist;
    urs_pkg::t_dist                     r_nearest;
    logic [1:0]                         r_active;
    logic                               r_done;
    logic                               r_tout;

    logic                               out_free;
    logic                               fire;
    logic                               in_take;

    urs_pkg::t_meas                     meas;
    logic [TICK_BITS-1:0]               width;
    logic [IDX_W-1:0]                   idx;
    logic [IDX_W-1:0]                   idx_next;
    logic [urs_pkg::ECHO_LINES-1:0]     trig_next;
    urs_pkg::t_dist [urs_pkg::ECHO_LINES-1:0] dist_next;
    urs_pkg::t_dist                     nearest_next;

    // handshake: the result register frees when empty or drained this cycle
    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale   <= urs_pkg::RST_SCALE;
            r_cfg.max_mm  <= urs_pkg::RST_MAX_MM;
            r_cfg.settle  <= urs_pkg::RST_SETTLE;
            r_cfg.timeout <= urs_pkg::RST_TIMEOUT;
            r_cfg.lead    <= urs_pkg::RST_TRIG_LEAD;
            r_cfg.pulse   <= urs_pkg::RST_TRIG_PULSE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                urs_pkg::CFG_SCALE:      r_cfg.scale   <= i_cfg_data;
                urs_pkg::CFG_MAX_MM:     r_cfg.max_mm  <= i_cfg_data;
                urs_pkg::CFG_SETTLE:     r_cfg.settle  <= i_cfg_data;
                urs_pkg::CFG_TIMEOUT:    r_cfg.timeout <= i_cfg_data;
                urs_pkg::CFG_TRIG_LEAD:  r_cfg.lead    <= i_cfg_data[7:0];
                urs_pkg::CFG_TRIG_PULSE: r_cfg.pulse   <= i_cfg_data[7:0];
                default: ;  // unmapped index: write ignored
            endcase
        end
    end

    // tick register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_echo <= i_echo_levels;
        end
    end

    urs_timing #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TICK_BITS    (TICK_BITS),
        .IDX_W        (IDX_W)
    ) u_timing (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_echo      (r_in_echo),
        .i_cfg       (r_cfg),
        .o_meas      (meas),
        .o_width     (width),
        .o_idx       (idx),
        .o_idx_next  (idx_next),
        .o_trig_next (trig_next)
    );

    urs_range #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .TICK_BITS    (TICK_BITS),
        .IDX_W        (IDX_W)
    ) u_range (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_meas         (meas),
        .i_width        (width),
        .i_idx          (idx),
        .i_cfg          (r_cfg),
        .o_dist_next    (dist_next),
        .o_nearest_next (nearest_next)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_trig    <= trig_next;
            r_dist    <= dist_next;
            r_nearest <= nearest_next;
            r_active  <= 2'(idx_next);
            r_done    <= meas.done;
            r_tout    <= meas.tout;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_trigger_lines    = r_trig;
    assign o_distance_zero    = r_dist[0];
    assign o_distance_one     = r_dist[1];
    assign o_distance_two     = r_dist[2];
    assign o_nearest_distance = r_nearest;
    assign o_active_sensor    = r_active;
    assign o_measurement_done = r_done;
    assign o_timed_out        = r_tout;

    // a timeout is always reported as an ended measurement
    a_tout_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_timed_out) |-> o_measurement_done)
        else $error("timeout without measurement end");

    // at most one trigger line driven
    a_trig_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot0(o_trigger_lines))
        else $error("more than one trigger line high");

    // the tick that ends a measurement returns to settling, so no trigger
    a_done_no_trig: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_measurement_done) |-> (o_trigger_lines == '0))
        else $error("trigger high on measurement end");

    // a request leaving the tick register always lands in the result register
    a_fire_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("request lost between stages");

endmodule
